// ===== hdl/gvlr_pkg.sv =====
// Package for grid_vertex_level_rank: field widths, reset and limit constants,
// and the small helper functions shared by the datapath.
// Depends on nothing.
package gvlr_pkg;

  localparam int COORD_W = 9;   // col_x, row_z, row_size
  localparam int LEVEL_W = 4;
  localparam int INDEX_W = 17;  // sorted_index, level_count

  localparam logic [COORD_W-1:0] MAX_ROW_SIZE   = 9'd257;
  localparam logic [COORD_W-1:0] ROW_SIZE_RESET = 9'd33;

  // floor(log2(n)); returns 0 for n of 0 or 1
  function automatic logic [LEVEL_W-1:0] floor_log2(input logic [COORD_W-1:0] n);
    logic [LEVEL_W-1:0] r;
    r = '0;
    for (int i = 0; i < COORD_W; i++) begin
      if (n[i]) r = LEVEL_W'(i);
    end
    return r;
  endfunction

  // min(trailing zeros of xz, top); zero counts as unbounded
  function automatic logic [LEVEL_W-1:0] vertex_level(input logic [COORD_W-1:0] xz,
                                                      input logic [LEVEL_W-1:0] top);
    logic [LEVEL_W-1:0] lev;
    lev = top;
    for (int i = COORD_W - 1; i >= 0; i--) begin
      if (xz[i] && (LEVEL_W'(i) < top)) lev = LEVEL_W'(i);
    end
    return lev;
  endfunction

  // number of multiples of 2^k in [0, v)
  function automatic logic [COORD_W-1:0] mult_below(input logic [COORD_W-1:0] v,
                                                    input logic [LEVEL_W-1:0] k);
    logic [COORD_W:0] sum;
    sum = {1'b0, v} + (((COORD_W+1)'(1) << k) - (COORD_W+1)'(1));
    return COORD_W'(sum >> k);
  endfunction

endpackage

// ===== hdl/grid_vertex_level_rank.sv =====
// grid_vertex_level_rank: usage notes
// Input channel (in_valid/in_stall, in_col_x, in_row_z): one grid vertex per
// request. Result channel (out_valid/out_stall): one result per request with
// out_sorted_index, out_level, out_level_count and out_out_of_range, in order.
// cfg_wr_en/cfg_wr_data write the row size (values above 257 saturate); write
// it only while no request is in flight. Reset sets the row size to 33.
// A vertex is the coarsest level it belongs to, ranked by descending level,
// then row, then column; the rank and the level population are computed in
// closed form from the row size, no table is stored.
// Pipeline: a request is captured in the input register, then its result is
// loaded into the result register (four 9x9 multipliers and the adds sit
// between them).
// Throughput: one request per cycle, sustained while out_stall stays low.
// Reset (synchronous, rst_n low) empties both stages.
// When out_stall is high and a result is held, the result register holds; a
// request still enters the input register if it is empty, and in_stall rises
// only when both stages are full.
// Depends on gvlr_pkg.
module grid_vertex_level_rank import gvlr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [COORD_W-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_W-1:0]   in_col_x,
  input  logic [COORD_W-1:0]   in_row_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [INDEX_W-1:0]   out_sorted_index,
  output logic [LEVEL_W-1:0]   out_level,
  output logic [INDEX_W-1:0]   out_level_count,
  output logic                 out_out_of_range
);

  logic [COORD_W-1:0]   row_size_r;
  logic                 s1_valid_r;
  logic [COORD_W-1:0]   s1_x_r;
  logic [COORD_W-1:0]   s1_z_r;
  logic                 out_valid_r;
  logic [INDEX_W-1:0]   idx_r;
  logic [LEVEL_W-1:0]   lev_r;
  logic [INDEX_W-1:0]   cnt_r;
  logic                 oor_r;

  logic                 out_free;
  logic                 s1_load;

  logic                 oor;
  logic [LEVEL_W-1:0]   top;
  logic [LEVEL_W-1:0]   lev;
  logic [LEVEL_W-1:0]   lev_p1;
  logic                 coarser;
  logic [COORD_W-1:0]   nm1;
  logic [COORD_W-1:0]   m0;
  logic [COORD_W-1:0]   m1;
  logic [COORD_W-1:0]   mbz0;
  logic [COORD_W-1:0]   mbz1;
  logic [COORD_W-1:0]   mbx0;
  logic [COORD_W-1:0]   mbx1;
  logic [COORD_W-1:0]   z_sh;
  logic [2*COORD_W-1:0] m0_sq;
  logic [2*COORD_W-1:0] m1_sq;
  logic [2*COORD_W-1:0] pz0;
  logic [2*COORD_W-1:0] pz1;
  logic [INDEX_W-1:0]   prior_cnt;
  logic [INDEX_W-1:0]   idx_nxt;
  logic [INDEX_W-1:0]   cnt_nxt;
  logic [LEVEL_W-1:0]   lev_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || out_free;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_size_r <= ROW_SIZE_RESET;
    end else if (cfg_wr_en) begin
      row_size_r <= (cfg_wr_data > MAX_ROW_SIZE) ? MAX_ROW_SIZE : cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_x_r <= in_col_x;
      s1_z_r <= in_row_z;
    end
  end

  // level and closed-form rank
  always_comb begin
    oor     = (s1_x_r >= row_size_r) || (s1_z_r >= row_size_r);
    top     = floor_log2(row_size_r);
    lev     = vertex_level(s1_x_r | s1_z_r, top);
    lev_p1  = lev + 4'd1;
    coarser = lev < top;
    nm1     = row_size_r - 9'd1;
    m0      = (nm1 >> lev) + 9'd1;
    m1      = coarser ? ((nm1 >> lev_p1) + 9'd1) : '0;
    mbz0    = mult_below(s1_z_r, lev);
    mbz1    = mult_below(s1_z_r, lev_p1);
    mbx0    = mult_below(s1_x_r, lev);
    mbx1    = mult_below(s1_x_r, lev_p1);
    z_sh    = s1_z_r >> lev;
    m0_sq   = m0 * m0;
    m1_sq   = m1 * m1;
    pz0     = mbz0 * m0;
    pz1     = mbz1 * m1;
    // earlier rows, then same row with smaller column, each minus the coarser vertices there
    prior_cnt = pz0[INDEX_W-1:0] - pz1[INDEX_W-1:0] + {8'b0, mbx0};
    if (coarser && !z_sh[0]) prior_cnt = prior_cnt - {8'b0, mbx1};
    idx_nxt = oor ? '0 : (m1_sq[INDEX_W-1:0] + prior_cnt);
    cnt_nxt = oor ? '0 : (m0_sq[INDEX_W-1:0] - m1_sq[INDEX_W-1:0]);
    lev_nxt = oor ? '0 : lev;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      idx_r <= idx_nxt;
      lev_r <= lev_nxt;
      cnt_r <= cnt_nxt;
      oor_r <= oor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_index = idx_r;
  assign out_level        = lev_r;
  assign out_level_count  = cnt_r;
  assign out_out_of_range = oor_r;

endmodule

// ===== hdl/gvlr_checker.sv =====
// Port-level checker for grid_vertex_level_rank, attached by bind.
// Depends on gvlr_pkg.
module gvlr_checker import gvlr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [INDEX_W-1:0]   out_sorted_index,
  input logic [LEVEL_W-1:0]   out_level,
  input logic [INDEX_W-1:0]   out_level_count,
  input logic                 out_out_of_range
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_index) &&
      $stable(out_level) && $stable(out_level_count) && $stable(out_out_of_range))
    else $error("stalled result changed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_sorted_index == '0 &&
      out_level == '0 && out_level_count == '0)
    else $error("out-of-range result carries nonzero fields");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |-> out_level_count != '0 && out_level <= 4'd8)
    else $error("in-range result with empty level or bad level");

endmodule

bind grid_vertex_level_rank gvlr_checker u_gvlr_checker (.*);
